/* sv/ses_pkg.sv */
package ses_pkg;

    // field and register widths
    localparam int MAX_ALT_DEF = 16;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = 48;
    localparam int SMP_W       = 32;
    localparam int ICPT_W      = 40;
    localparam int SLOPE_W     = 32;
    localparam int RND_W       = 16;
    localparam int TOT_W       = 32;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICPT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd2;

    localparam logic [CNT_W-1:0] ALTS_RST = 7'd16;

    // controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             add;
        logic             scan_rd;
        logic             scan_elim;
        logic [IDX_W-1:0] scan_idx;
        logic             out_load;
    } t_ses_cmd;

    // datapath to controller status
    typedef struct packed {
        logic eor;
        logic out_free;
    } t_ses_sts;

endpackage

/* sv/ses_ctrl.sv */
module ses_ctrl #(
    parameter int MAX_ALTERNATIVES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ses_pkg::t_ses_sts i_sts,
    output ses_pkg::t_ses_cmd o_cmd
);
    import ses_pkg::*;

    localparam int CW = $clog2(MAX_ALTERNATIVES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_BEST = 3'd2;
    localparam logic [2:0] S_ELIM = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          scan_end;

    assign scan_end = (r_cnt == CW'(MAX_ALTERNATIVES));

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.scan_idx  = IDX_W'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.eor ? S_BEST : S_IDLE;
            end
            S_BEST: begin
                if (scan_end) begin
                    n_cnt   = '0;
                    n_state = S_ELIM;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            S_ELIM: begin
                if (scan_end) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_rd   = 1'b1;
                    o_cmd.scan_elim = 1'b1;
                    n_cnt           = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ALTERNATIVES))
        else $error("scan counter past the last alternative");

    a_add_follows_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_ADD)
        else $error("accepted item not followed by accumulate step");

    a_out_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_cmd.out_load)
        else $error("two result loads in a row");
`endif

endmodule

/* sv/ses_dp.sv */
module ses_dp #(
    parameter int MAX_ALTERNATIVES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [ses_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ses_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_new_run,
    input  logic [ses_pkg::IDX_W-1:0]            i_alt_index,
    input  logic signed [ses_pkg::SMP_W-1:0]     i_sample_value,
    input  logic                                 i_end_of_round,
    input  ses_pkg::t_ses_cmd                    i_cmd,
    output ses_pkg::t_ses_sts                    o_sts,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_finished,
    output logic [ses_pkg::IDX_W-1:0]            o_best_index,
    output logic [ses_pkg::CNT_W-1:0]            o_active_count,
    output logic [ses_pkg::MASK_W-1:0]           o_active_mask,
    output logic [ses_pkg::RND_W-1:0]            o_rounds_done,
    output logic [ses_pkg::TOT_W-1:0]            o_samples_taken
);
    import ses_pkg::*;

    localparam int AW   = $clog2(MAX_ALTERNATIVES);
    localparam int LIMW = SUM_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_MAXV = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MINV = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration registers
    logic [CNT_W-1:0]   r_cfg_alts;
    logic [ICPT_W-1:0]  r_cfg_icpt;
    logic [SLOPE_W-1:0] r_cfg_slope;

    // captured item
    logic [IDX_W-1:0]        r_idx;
    logic signed [SMP_W-1:0] r_sample;
    logic                    r_eor;

    // run state
    logic [MAX_ALTERNATIVES-1:0] r_active, n_active;
    logic [MAX_ALTERNATIVES-1:0] r_valid;
    logic [CNT_W-1:0]            r_active_total, n_active_total;
    logic [RND_W-1:0]            r_round, n_round;
    logic [TOT_W-1:0]            r_sample_total;
    logic                        r_done;

    // sum memory
    logic signed [SUM_W-1:0] r_mem [MAX_ALTERNATIVES];
    logic signed [SUM_W-1:0] r_rd;
    logic [IDX_W-1:0]        rd_addr_full;
    logic [AW-1:0]           rd_addr;

    // scan pipeline and best tracking
    logic                    r_p_vld, r_p_elim;
    logic [AW-1:0]           r_p_idx;
    logic                    r_best_vld;
    logic [AW-1:0]           r_best_idx;
    logic signed [SUM_W-1:0] r_best_sum;
    logic [SUM_W-1:0]        r_prod;
    logic [ICPT_W-1:0]       r_w;
    logic signed [LIMW-1:0]  r_limit;

    // output registers
    logic                    r_o_valid;
    logic                    r_o_finished;
    logic [IDX_W-1:0]        r_o_best;
    logic [CNT_W-1:0]        r_o_count;
    logic [MASK_W-1:0]       r_o_mask;
    logic [RND_W-1:0]        r_o_rounds;
    logic [TOT_W-1:0]        r_o_samples;

    logic [CNT_W-1:0]        eff_n;
    logic [AW-1:0]           idx_tr;
    logic                    add_ok;
    logic signed [SUM_W:0]   add_wide;
    logic signed [SUM_W-1:0] add_sat;
    logic signed [SUM_W-1:0] add_base;
    logic signed [SUM_W-1:0] scan_sum;
    logic                    best_take;
    logic                    elim_take;
    logic [MASK_W-1:0]       mask_now;

    // effective alternative count
    assign eff_n = (r_cfg_alts < CNT_W'(MAX_ALTERNATIVES)) ? r_cfg_alts
                                                            : CNT_W'(MAX_ALTERNATIVES);

    // accumulate step
    assign idx_tr   = r_idx[AW-1:0];
    assign add_ok   = !r_done && ({1'b0, r_idx} < eff_n) && r_active[idx_tr];
    assign add_base = r_valid[idx_tr] ? r_rd : '0;
    assign add_wide = {add_base[SUM_W-1], add_base}
                    + {{(SUM_W+1-SMP_W){r_sample[SMP_W-1]}}, r_sample};
    always_comb begin
        if (add_wide[SUM_W] != add_wide[SUM_W-1]) begin
            add_sat = add_wide[SUM_W] ? SUM_MINV : SUM_MAXV;
        end else begin
            add_sat = add_wide[SUM_W-1:0];
        end
    end

    // memory read address, the index is cut to its low bits and those past the store read entry zero
    assign rd_addr_full = i_cmd.capture ? i_alt_index : i_cmd.scan_idx;
    always_comb begin
        if ({1'b0, rd_addr_full[AW-1:0]} < (AW+1)'(MAX_ALTERNATIVES)) begin
            rd_addr = rd_addr_full[AW-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    // sum memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && add_ok) begin
            r_mem[idx_tr] <= add_sat;
        end
        r_rd <= r_mem[rd_addr];
    end

    // scan compare against best and limit
    assign scan_sum  = r_valid[r_p_idx] ? r_rd : '0;
    assign best_take = r_p_vld && !r_p_elim && r_active[r_p_idx]
                    && (!r_best_vld || (scan_sum > r_best_sum));
    assign elim_take = r_p_vld && r_p_elim && r_best_vld && !r_done
                    && r_active[r_p_idx] && (r_p_idx != r_best_idx)
                    && ($signed({{2{scan_sum[SUM_W-1]}}, scan_sum}) < r_limit);

    // active flags and count
    always_comb begin
        n_active       = r_active;
        n_active_total = r_active_total;
        if (i_cmd.capture && i_new_run) begin
            for (int i = 0; i < MAX_ALTERNATIVES; i++) begin
                n_active[i] = (CNT_W'(i) < eff_n);
            end
            n_active_total = eff_n;
        end else if (elim_take) begin
            n_active[r_p_idx] = 1'b0;
            n_active_total    = r_active_total - 1'b1;
        end
    end

    // round counter after this round
    always_comb begin
        n_round = r_round;
        if (!r_done && (r_round != {RND_W{1'b1}})) begin
            n_round = r_round + 1'b1;
        end
    end

    // active mask, alternatives beyond the store read as clear
    always_comb begin
        mask_now = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < MAX_ALTERNATIVES) begin
                mask_now[i] = r_active[i];
            end
        end
    end

    // control and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_alts     <= ALTS_RST;
            r_cfg_icpt     <= '0;
            r_cfg_slope    <= '0;
            r_active       <= '0;
            r_valid        <= '0;
            r_active_total <= '0;
            r_round        <= '0;
            r_sample_total <= '0;
            r_done         <= 1'b0;
            r_eor          <= 1'b0;
            r_p_vld        <= 1'b0;
            r_p_elim       <= 1'b0;
            r_best_vld     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ALTS:  r_cfg_alts  <= i_cfg_data[CNT_W-1:0];
                    CFG_ICPT:  r_cfg_icpt  <= i_cfg_data[ICPT_W-1:0];
                    CFG_SLOPE: r_cfg_slope <= i_cfg_data[SLOPE_W-1:0];
                    default: ;
                endcase
            end
            r_active       <= n_active;
            r_active_total <= n_active_total;
            r_p_vld        <= i_cmd.scan_rd;
            r_p_elim       <= i_cmd.scan_elim;
            // item capture and new run clear
            if (i_cmd.capture) begin
                r_eor      <= i_end_of_round;
                r_best_vld <= 1'b0;
                if (i_new_run) begin
                    r_valid        <= '0;
                    r_round        <= '0;
                    r_sample_total <= '0;
                    r_done         <= 1'b0;
                end
            end
            // accumulate
            if (i_cmd.add && add_ok) begin
                r_valid[idx_tr] <= 1'b1;
                if (r_sample_total != {TOT_W{1'b1}}) begin
                    r_sample_total <= r_sample_total + 1'b1;
                end
            end
            if (best_take) begin
                r_best_vld <= 1'b1;
            end
            // close the round and present the result
            if (i_cmd.out_load) begin
                r_round <= n_round;
                if (!r_done && (r_active_total == CNT_W'(1))) begin
                    r_done <= 1'b1;
                end
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx    <= i_alt_index;
            r_sample <= i_sample_value;
        end
        if (best_take) begin
            r_best_idx <= r_p_idx;
            r_best_sum <= scan_sum;
        end
        r_p_idx <= i_cmd.scan_idx[AW-1:0];
        // margin: intercept minus rounds times slope, floored at zero
        r_prod  <= SUM_W'(r_round) * SUM_W'(r_cfg_slope);
        if (SUM_W'(r_cfg_icpt) > r_prod) begin
            r_w <= r_cfg_icpt - r_prod[ICPT_W-1:0];
        end else begin
            r_w <= '0;
        end
        r_limit <= $signed({{2{r_best_sum[SUM_W-1]}}, r_best_sum})
                 - $signed({{(LIMW-ICPT_W){1'b0}}, r_w});
        if (i_cmd.out_load) begin
            r_o_finished <= (r_active_total == CNT_W'(1));
            r_o_best     <= r_best_vld ? IDX_W'(r_best_idx) : '0;
            r_o_count    <= r_active_total;
            r_o_mask     <= mask_now;
            r_o_rounds   <= n_round;
            r_o_samples  <= r_sample_total;
        end
    end

    assign o_sts.eor      = r_eor;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid     = r_o_valid;
    assign o_finished      = r_o_finished;
    assign o_best_index    = r_o_best;
    assign o_active_count  = r_o_count;
    assign o_active_mask   = r_o_mask;
    assign o_rounds_done   = r_o_rounds;
    assign o_samples_taken = r_o_samples;

`ifndef SYNTHESIS
    a_total_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_total == CNT_W'($countones(r_active)))
        else $error("active count differs from active flags");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_active_total == CNT_W'(1)))
        else $error("run finished without a single survivor");

    a_best_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_vld |-> r_active[r_best_idx])
        else $error("best alternative is not active");
`endif

endmodule

/* sv/sequential_elimination_screen_top.sv */
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_new_run, i_alt_index, i_sample_value,
//         |           |                            | i_end_of_round
// result  | out       | o_out_valid / i_out_ready  | o_finished, o_best_index, o_active_count,
//         |           |                            | o_active_mask, o_rounds_done, o_samples_taken
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an item without end of round is captured with its sum read, then added and written back
// an end of round item makes two passes over the sum memory
//   (best search, then elimination), one read port entry per cycle, plus result load
// a result waiting in the output register holds the next end of round item in its last step
// reset (synchronous, active low) clears the run state; no clearing pass is needed
// config writes are always taken
module sequential_elimination_screen_top #(
    parameter int MAX_ALTERNATIVES = ses_pkg::MAX_ALT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_new_run,
    input  logic [ses_pkg::IDX_W-1:0]            i_alt_index,
    input  logic signed [ses_pkg::SMP_W-1:0]     i_sample_value,
    input  logic                                 i_end_of_round,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_finished,
    output logic [ses_pkg::IDX_W-1:0]            o_best_index,
    output logic [ses_pkg::CNT_W-1:0]            o_active_count,
    output logic [ses_pkg::MASK_W-1:0]           o_active_mask,
    output logic [ses_pkg::RND_W-1:0]            o_rounds_done,
    output logic [ses_pkg::TOT_W-1:0]            o_samples_taken,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ses_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ses_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ses_pkg::*;

    t_ses_cmd cmd;
    t_ses_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ses_ctrl #(
        .MAX_ALTERNATIVES(MAX_ALTERNATIVES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // sums, flags, counters and result register
    ses_dp #(
        .MAX_ALTERNATIVES(MAX_ALTERNATIVES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_new_run       (i_new_run),
        .i_alt_index     (i_alt_index),
        .i_sample_value  (i_sample_value),
        .i_end_of_round  (i_end_of_round),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_finished      (o_finished),
        .o_best_index    (o_best_index),
        .o_active_count  (o_active_count),
        .o_active_mask   (o_active_mask),
        .o_rounds_done   (o_rounds_done),
        .o_samples_taken (o_samples_taken)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ses_pkg::*;

    localparam int NALT         = MAX_ALT_DEF;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * NALT + 20;

    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0] SMP_HI = 32'sh7FFF_FFFF;
    localparam logic signed [SMP_W-1:0] SMP_LO = 32'sh8000_0000;

    typedef struct packed {
        logic              finished;
        logic [IDX_W-1:0]  best_index;
        logic [CNT_W-1:0]  active_count;
        logic [MASK_W-1:0] active_mask;
        logic [RND_W-1:0]  rounds_done;
        logic [TOT_W-1:0]  samples_taken;
    } screen_report_t;

    // dut ports
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_new_run;
    logic [IDX_W-1:0]        i_alt_index;
    logic signed [SMP_W-1:0] i_sample_value;
    logic                    i_end_of_round;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_finished;
    logic [IDX_W-1:0]        o_best_index;
    logic [CNT_W-1:0]        o_active_count;
    logic [MASK_W-1:0]       o_active_mask;
    logic [RND_W-1:0]        o_rounds_done;
    logic [TOT_W-1:0]        o_samples_taken;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    // shadow copy of the screen state and its registers
    logic [CNT_W-1:0]        cfg_alts;
    logic [ICPT_W-1:0]       cfg_icpt;
    logic [SLOPE_W-1:0]      cfg_slope;
    logic signed [SUM_W-1:0] alt_sum [NALT];
    bit                      alt_live [NALT];
    logic [RND_W-1:0]        round_cnt;
    logic [CNT_W-1:0]        live_cnt;
    logic [TOT_W-1:0]        sample_cnt;
    bit                      run_done;

    screen_report_t pending_reports[$];
    screen_report_t want_rep;
    screen_report_t got_rep;

    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned stall_left;
    bit          gaps_on;

    sequential_elimination_screen_top DUT (.*);

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run time guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side back pressure in short bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_out_ready = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_ready = 1'b1;
        end
    end

    function automatic int unsigned eff_alts();
        return (cfg_alts < NALT) ? cfg_alts : NALT;
    endfunction

    function automatic void clear_screen();
        for (int i = 0; i < NALT; i++) begin
            alt_sum[i]  = '0;
            alt_live[i] = 1'b0;
        end
        round_cnt  = '0;
        live_cnt   = '0;
        sample_cnt = '0;
        run_done   = 1'b0;
    endfunction

    // fold one accepted observation into the shadow state, queue a report on end of round
    function automatic void apply_observation(logic nr, logic [IDX_W-1:0] idx,
                                              logic signed [SMP_W-1:0] smp, logic eor);
        int unsigned    n;
        int             best;
        longint         acc;
        longint         lim;
        logic [63:0]    prod;
        logic [63:0]    margin;
        screen_report_t rep;

        if (nr) begin
            clear_screen();
            n = eff_alts();
            for (int i = 0; i < n; i++)
                alt_live[i] = 1'b1;
            live_cnt = CNT_W'(n);
        end

        n = eff_alts();
        if (!run_done && idx < n && alt_live[idx]) begin
            acc = longint'(alt_sum[idx]) + longint'(smp);
            if (acc > longint'(SUM_HI))
                acc = longint'(SUM_HI);
            if (acc < longint'(SUM_LO))
                acc = longint'(SUM_LO);
            alt_sum[idx] = acc[SUM_W-1:0];
            if (sample_cnt != '1)
                sample_cnt++;
        end

        if (!eor)
            return;

        // best active sum, lowest index on ties
        best = -1;
        for (int i = 0; i < NALT; i++)
            if (alt_live[i] && (best < 0 || alt_sum[i] > alt_sum[best]))
                best = i;

        // screen against the shrinking margin, using the round count from before
        if (!run_done) begin
            if (best >= 0) begin
                prod   = 64'(round_cnt) * 64'(cfg_slope);
                margin = (64'(cfg_icpt) > prod) ? 64'(cfg_icpt) - prod : 64'd0;
                lim    = longint'(alt_sum[best]) - longint'(margin);
                for (int i = 0; i < NALT; i++) begin
                    if (alt_live[i] && i != best && longint'(alt_sum[i]) < lim) begin
                        alt_live[i] = 1'b0;
                        live_cnt--;
                    end
                end
            end
            if (round_cnt != '1)
                round_cnt++;
            if (live_cnt == 1)
                run_done = 1'b1;
        end

        rep.finished      = (live_cnt == 1);
        rep.best_index    = (best >= 0) ? best[IDX_W-1:0] : '0;
        rep.active_count  = live_cnt;
        for (int i = 0; i < MASK_W; i++)
            rep.active_mask[i] = alt_live[i];
        rep.rounds_done   = round_cnt;
        rep.samples_taken = sample_cnt;
        pending_reports.push_back(rep);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // predict on every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            apply_observation(i_new_run, i_alt_index, i_sample_value, i_end_of_round);
    end

    // compare every accepted report with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report arrived with none pending");
                err_cnt++;
            end else begin
                want_rep = pending_reports.pop_front();
                got_rep  = {o_finished, o_best_index, o_active_count, o_active_mask,
                            o_rounds_done, o_samples_taken};
                check_field("finished", want_rep.finished, got_rep.finished);
                check_field("best_index", want_rep.best_index, got_rep.best_index);
                check_field("active_count", want_rep.active_count, got_rep.active_count);
                check_field("active_mask", want_rep.active_mask, got_rep.active_mask);
                check_field("rounds_done", want_rep.rounds_done, got_rep.rounds_done);
                check_field("samples_taken", want_rep.samples_taken, got_rep.samples_taken);
            end
        end
    end

    // send one item, called at a falling edge, returns at a falling edge
    task automatic send_item(input logic nr, input logic [IDX_W-1:0] idx,
                             input logic signed [SMP_W-1:0] smp, input logic eor);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_new_run      = nr;
        i_alt_index    = idx;
        i_sample_value = smp;
        i_end_of_round = eor;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ALTS:  cfg_alts  = data[CNT_W-1:0];
            CFG_ICPT:  cfg_icpt  = data[ICPT_W-1:0];
            CFG_SLOPE: cfg_slope = data[SLOPE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for all reports, then for any item still in flight
    task automatic wait_drain();
        while (pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // all three registers, junk in the unused upper bits
    task automatic set_config(input logic [CNT_W-1:0] alts, input logic [ICPT_W-1:0] icpt,
                              input logic [SLOPE_W-1:0] slope);
        logic [CFG_DATA_W-1:0] word;
        wait_drain();
        word = CFG_DATA_W'({$urandom, $urandom});
        word[CNT_W-1:0] = alts;
        write_reg(CFG_ALTS, word);
        write_reg(CFG_ICPT, icpt);
        word = CFG_DATA_W'({$urandom, $urandom});
        word[SLOPE_W-1:0] = slope;
        write_reg(CFG_SLOPE, word);
    endtask

    // screening with nothing active yet
    task automatic test_idle_before_run();
        send_item(1'b0, 6'd0, 32'sd1000, 1'b0);
        send_item(1'b0, 6'd5, -32'sd5, 1'b1);
        send_item(1'b0, 6'd63, SMP_HI, 1'b1);
    endtask

    // tie on the best sum, margin extremes, slope driving the margin to zero
    task automatic test_ties_and_margin();
        set_config(7'd4, '0, '0);
        send_item(1'b1, 6'd0, 32'sh100, 1'b0);
        send_item(1'b0, 6'd1, 32'sh100, 1'b0);
        send_item(1'b0, 6'd2, 32'sh80, 1'b0);
        send_item(1'b0, 6'd3, 32'sh100, 1'b1);
        set_config(7'd4, '1, '1);
        send_item(1'b0, 6'd1, -32'sh1000, 1'b0);
        send_item(1'b0, 6'd63, 32'sh5, 1'b1);
        set_config(7'd4, 40'h1_0000, '1);
        send_item(1'b0, 6'd0, 32'sd0, 1'b1);
    endtask

    // count lowered mid run, then items after the run has finished
    task automatic test_count_change();
        set_config(7'd16, '0, '0);
        send_item(1'b1, 6'd15, -32'sd1, 1'b0);
        set_config(7'd4, '0, '0);
        send_item(1'b0, 6'd8, 32'sh1234, 1'b0);
        send_item(1'b0, 6'd3, SMP_HI, 1'b0);
        send_item(1'b0, 6'd63, SMP_LO, 1'b1);
        send_item(1'b0, 6'd3, 32'sd5, 1'b0);
        send_item(1'b0, 6'd3, 32'sd5, 1'b1);
    endtask

    // counts of zero, one, above the array size and the field maximum
    task automatic test_extreme_counts();
        set_config(7'd0, '0, '0);
        send_item(1'b1, 6'd0, 32'sh10, 1'b1);
        set_config(7'd1, '0, '0);
        send_item(1'b1, 6'd0, SMP_HI, 1'b0);
        send_item(1'b0, 6'd0, SMP_LO, 1'b1);
        set_config(7'd127, '0, '0);
        send_item(1'b1, 6'd15, SMP_LO, 1'b1);
        set_config(7'd64, '1, '0);
        send_item(1'b1, 6'd63, 32'sd1, 1'b1);
    endtask

    // whole runs with noisy per-alternative levels, some noise and broken rounds
    task automatic test_random_runs(input int unsigned item_goal);
        int unsigned             sent;
        int unsigned             span;
        int unsigned             k;
        int unsigned             kind;
        bit                      wide;
        bit                      first;
        logic [CNT_W-1:0]        alts;
        logic [ICPT_W-1:0]       icpt;
        logic [SLOPE_W-1:0]      slope;
        logic signed [SMP_W-1:0] level [NALT];
        logic signed [SMP_W-1:0] smp;
        logic [IDX_W-1:0]        idx;
        logic                    nr;
        logic                    eor;

        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(0, 19))
                0:       alts = 7'd0;
                1:       alts = 7'd1;
                2:       alts = 7'd64;
                3:       alts = 7'd127;
                4:       alts = CNT_W'($urandom_range(17, 126));
                default: alts = CNT_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 7))
                0:       icpt = '0;
                1:       icpt = '1;
                default: icpt = ICPT_W'($urandom_range(0, 1 << 22));
            endcase
            case ($urandom_range(0, 7))
                0:       slope = '0;
                1:       slope = '1;
                default: slope = $urandom_range(0, 1 << 20);
            endcase
            set_config(alts, icpt, slope);

            wide = ($urandom_range(0, 5) == 0);
            span = (eff_alts() == 0) ? 1 : eff_alts();
            for (int i = 0; i < NALT; i++)
                level[i] = wide ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19);

            first = 1'b1;
            for (int r = 0; r < 12 && !(run_done && !first); r++) begin
                k = span + $urandom_range(0, 2);
                for (int j = 0; j < k; j++) begin
                    kind = $urandom_range(0, 39);
                    nr   = first || kind == 2;
                    eor  = (j == k - 1) || kind == 3;
                    if (kind < 2) begin
                        idx = IDX_W'($urandom_range(0, 63));
                        smp = $urandom;
                    end else begin
                        idx = IDX_W'($urandom_range(0, span - 1));
                        smp = wide ? $urandom
                                   : level[idx] + $urandom_range(0, 1 << 18) - (1 << 17);
                    end
                    send_item(nr, idx, smp, eor);
                    first = 1'b0;
                    sent++;
                end
            end

            // poke the finished state once
            if (run_done) begin
                send_item(1'b0, IDX_W'($urandom_range(0, span - 1)), $urandom,
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // push two sums far apart at full sample scale, then screen across a wide range
    task automatic test_wide_sums();
        set_config(7'd2, '1, '0);
        send_item(1'b1, 6'd0, SMP_HI, 1'b0);
        send_item(1'b0, 6'd1, SMP_LO, 1'b0);
        repeat (24) begin
            send_item(1'b0, 6'd0, SMP_HI, 1'b0);
            send_item(1'b0, 6'd1, SMP_LO, 1'b0);
        end
        send_item(1'b0, 6'd2, 32'sd0, 1'b1);
    endtask

    // sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_new_run      = 1'b0;
        i_alt_index    = '0;
        i_sample_value = '0;
        i_end_of_round = 1'b0;
        i_out_ready    = 1'b1;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ALTS;
        i_cfg_data     = '0;
        err_cnt        = 0;
        cycle_cnt      = 0;
        stall_left     = 0;
        gaps_on        = 1'b0;
        cfg_alts       = ALTS_RST;
        cfg_icpt       = '0;
        cfg_slope      = '0;
        clear_screen();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_before_run();
        test_ties_and_margin();
        test_count_change();
        test_extreme_counts();
        gaps_on = 1'b1;
        test_random_runs(500);
        gaps_on = 1'b0;
        test_random_runs(50);
        test_wide_sums();
        wait_drain();

        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
